// ----- hw/rtl/brb_pkg.sv -----
// package for the byte ring buffer
// holds the default sizes, the opcode and error codes and the fixed field widths
package brb_pkg;

	localparam int STORE_BYTES_DEF = 256;
	localparam int LANE_BYTES_DEF  = 8;

	localparam int OPC_W   = 2;
	localparam int CNT_F_W = 4;
	localparam int DATA_W  = 64;
	localparam int ERR_W   = 2;
	localparam int LVL_W   = 9;

	localparam logic [OPC_W-1:0] OP_WR_PART = 2'd0;
	localparam logic [OPC_W-1:0] OP_WR_ALL  = 2'd1;
	localparam logic [OPC_W-1:0] OP_RD_PART = 2'd2;
	localparam logic [OPC_W-1:0] OP_RD_ALL  = 2'd3;

	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

endpackage

// ----- hw/rtl/byte_ring_buffer_top.sv -----
// byte ring buffer top level: fifo of bytes in a circular store
// depends on brb_pkg and brb_ram
//
// Each input beat asks for a partial or all-or-nothing write or read of up to
// LANE_BYTES bytes (byte_count above LANE_BYTES counts as LANE_BYTES) and gives
// exactly one result beat with the bytes moved, the read bytes (first byte in
// bits 7:0, unused bytes and writes zero), an error code and the fill level and
// free space afterwards. The store is one byte-wide ram with a registered read,
// accessed one byte per cycle, so items are handled one at a time: a write of
// n bytes writes them in turn, a read of n bytes then waits for its last byte,
// and an item moving nothing skips to its result. A new beat is taken while the
// previous result still waits on out_stall; the store needs no clearing pass.
module byte_ring_buffer_top
	import brb_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int LANE_BYTES  = LANE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [brb_pkg::OPC_W-1:0]   opcode,
	input  logic [brb_pkg::CNT_F_W-1:0] byte_count,
	input  logic [brb_pkg::DATA_W-1:0]  write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [brb_pkg::CNT_F_W-1:0] moved_count,
	output logic [brb_pkg::DATA_W-1:0]  read_data,
	output logic [brb_pkg::ERR_W-1:0]   error_code,
	output logic [brb_pkg::LVL_W-1:0]   fill_level,
	output logic [brb_pkg::LVL_W-1:0]   free_space
);

	localparam int PTR_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CNT_W  = $clog2(STORE_BYTES + 1);
	localparam int LANE_W = 3;
	localparam logic [CNT_F_W-1:0] LANE_CNT = CNT_F_W'(LANE_BYTES);
	localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(STORE_BYTES - 1);
	localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(STORE_BYTES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_RDWAIT,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [PTR_W-1:0]   wptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               op_wr_q;
	logic [CNT_F_W-1:0] moved_q;
	logic [CNT_F_W-1:0] idx_q;
	logic [ERR_W-1:0]   err_q;
	logic [DATA_W-1:0]  wdata_q;
	logic [DATA_W-1:0]  rdata_q;
	logic               rd_vld_s1;
	logic [LANE_W-1:0]  rd_lane_s1;
	logic               out_valid_q;

	logic [CNT_F_W-1:0] req;
	logic [CNT_W-1:0]   space;
	logic               is_wr;
	logic               all_or_none;
	logic [CNT_F_W-1:0] moved_d;
	logic [ERR_W-1:0]   err_d;
	logic [CNT_F_W-1:0] idx_nxt;
	logic               accept;
	logic               out_free;
	logic [CNT_W-1:0]   count_nxt;
	logic [CNT_W-1:0]   free_nxt;
	logic [CNT_W+LVL_W-1:0] fill_ext;
	logic [CNT_W+LVL_W-1:0] free_ext;

	logic               mem_wr_en;
	logic               mem_rd_en;
	logic [7:0]         mem_wr_data;
	logic [7:0]         mem_rd_data;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign idx_nxt   = idx_q + CNT_F_W'(1);

	always_comb begin
		req         = (byte_count > LANE_CNT) ? LANE_CNT : byte_count;
		space       = CNT_FULL - count_q;
		is_wr       = (opcode == OP_WR_PART) || (opcode == OP_WR_ALL);
		all_or_none = (opcode == OP_WR_ALL) || (opcode == OP_RD_ALL);
		moved_d     = req;
		err_d       = ERR_NONE;
		if (req == '0) begin
			moved_d = '0;
		end else if (is_wr) begin
			if (CNT_W'(req) > space) begin
				err_d   = ERR_OVERFLOW;
				moved_d = all_or_none ? '0 : space[CNT_F_W-1:0];
			end
		end else begin
			if (CNT_W'(req) > count_q) begin
				err_d   = ERR_UNDERFLOW;
				moved_d = all_or_none ? '0 : count_q[CNT_F_W-1:0];
			end
		end
	end

	always_comb begin
		count_nxt = op_wr_q ? (count_q + CNT_W'(moved_q)) : (count_q - CNT_W'(moved_q));
		free_nxt  = CNT_FULL - count_nxt;
		fill_ext  = {{LVL_W{1'b0}}, count_nxt};
		free_ext  = {{LVL_W{1'b0}}, free_nxt};
	end

	assign mem_wr_en   = (state_q == S_WRITE);
	assign mem_rd_en   = (state_q == S_READ);
	assign mem_wr_data = wdata_q[idx_q[LANE_W-1:0]*8 +: 8];

	brb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(wptr_q),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(rptr_q),
		.rd_data(mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rptr_q      <= '0;
			wptr_q      <= '0;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			op_wr_q     <= 1'b0;
			moved_q     <= '0;
			idx_q       <= '0;
			err_q       <= ERR_NONE;
		end else begin
			rd_vld_s1 <= (state_q == S_READ);
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (rd_vld_s1) begin
				rdata_q[rd_lane_s1*8 +: 8] <= mem_rd_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_wr_q <= is_wr;
						moved_q <= moved_d;
						err_q   <= err_d;
						idx_q   <= '0;
						wdata_q <= write_data;
						rdata_q <= '0;
						if (moved_d == '0) begin
							state_q <= S_DONE;
						end else if (is_wr) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_WRITE: begin
					wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
					idx_q  <= idx_nxt;
					if (idx_nxt == moved_q) begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					rptr_q     <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
					idx_q      <= idx_nxt;
					rd_lane_s1 <= idx_q[LANE_W-1:0];
					if (idx_nxt == moved_q) begin
						state_q <= S_RDWAIT;
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						count_q     <= count_nxt;
						moved_count <= moved_q;
						read_data   <= rdata_q;
						error_code  <= err_q;
						fill_level  <= fill_ext[LVL_W-1:0];
						free_space  <= free_ext[LVL_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/brb_ram.sv -----
// generic single-clock ram, one write port and one read port
// read data is registered; no package dependency
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- test/tb.sv -----
// testbench for byte_ring_buffer_top: random and directed fifo traffic with random gaps
// on both channels, each result beat checked against a predictor of the byte ring
// depends on brb_pkg and the byte ring buffer rtl
module tb;
	import brb_pkg::*;

	localparam int RING_BYTES = STORE_BYTES_DEF;
	localparam int LANE = LANE_BYTES_DEF;
	localparam int PTR_W = $clog2(RING_BYTES);
	localparam int RANDOM_ITEMS = 1150;

	typedef struct {
		logic [OPC_W-1:0]   op;
		logic [CNT_F_W-1:0] cnt;
		logic [DATA_W-1:0]  data;
		bit                 drain;
	} request_t;

	typedef struct {
		logic [CNT_F_W-1:0] moved;
		logic [DATA_W-1:0]  rdata;
		logic [ERR_W-1:0]   err;
		logic [LVL_W-1:0]   fill;
		logic [LVL_W-1:0]   room;
	} transfer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OPC_W-1:0] opcode = '0;
	logic [CNT_F_W-1:0] byte_count = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CNT_F_W-1:0] moved_count;
	logic [DATA_W-1:0] read_data;
	logic [ERR_W-1:0] error_code;
	logic [LVL_W-1:0] fill_level;
	logic [LVL_W-1:0] free_space;

	request_t requests[$];
	transfer_t due_transfers[$];

	// predictor state
	logic [7:0] ring_mem [RING_BYTES];
	logic [PTR_W-1:0] head_ptr = '0;
	logic [PTR_W-1:0] tail_ptr = '0;
	int held_bytes = 0;

	int total_requests = 0;
	int sent_requests = 0;
	int mismatches = 0;
	int send_idle = 0;
	int stall_left = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	request_t beat;
	transfer_t want;

	byte_ring_buffer_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.byte_count (byte_count),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.moved_count(moved_count),
		.read_data  (read_data),
		.error_code (error_code),
		.fill_level (fill_level),
		.free_space (free_space)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic ring_transfer(input logic [OPC_W-1:0] op, input logic [CNT_F_W-1:0] cnt,
			input logic [DATA_W-1:0] data);
		transfer_t res;
		int want_n;
		int moved;
		res.rdata = '0;
		res.err = ERR_NONE;
		moved = 0;
		want_n = (cnt > LANE) ? LANE : cnt;
		if (want_n != 0) begin
			if (op == OP_WR_PART || op == OP_WR_ALL) begin
				if (want_n > RING_BYTES - held_bytes) begin
					res.err = ERR_OVERFLOW;
					if (op == OP_WR_PART)
						moved = RING_BYTES - held_bytes;
				end else begin
					moved = want_n;
				end
				for (int i = 0; i < moved; i++) begin
					ring_mem[tail_ptr] = data[8*i +: 8];
					tail_ptr = tail_ptr + 1'b1;
				end
				held_bytes += moved;
			end else begin
				if (want_n > held_bytes) begin
					res.err = ERR_UNDERFLOW;
					if (op == OP_RD_PART)
						moved = held_bytes;
				end else begin
					moved = want_n;
				end
				for (int i = 0; i < moved; i++) begin
					res.rdata[8*i +: 8] = ring_mem[head_ptr];
					head_ptr = head_ptr + 1'b1;
				end
				held_bytes -= moved;
			end
		end
		res.moved = moved[CNT_F_W-1:0];
		res.fill = held_bytes[LVL_W-1:0];
		res.room = LVL_W'(RING_BYTES - held_bytes);
		due_transfers.push_back(res);
	endtask

	task automatic add_request(input logic [OPC_W-1:0] op, input int cnt,
			input logic [DATA_W-1:0] data, input bit drain);
		request_t rq;
		rq.op = op;
		rq.cnt = cnt[CNT_F_W-1:0];
		rq.data = data;
		rq.drain = drain;
		requests.push_back(rq);
	endtask

	task automatic check_field(input string what, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %h actual %h", $time, what, exp_v, got_v);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_idle = 0;
		end else begin
			if (in_valid && !in_stall) begin
				ring_transfer(opcode, byte_count, write_data);
				sent_requests++;
				if ($urandom_range(0, 199) == 0)
					tx_calm = !tx_calm;
				send_idle = pick_gap(tx_calm);
			end
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (send_idle > 0) begin
				send_idle--;
				in_valid <= 1'b0;
			end else if (requests.size() != 0 &&
					!(requests[0].drain && due_transfers.size() != 0)) begin
				beat = requests.pop_front();
				opcode <= beat.op;
				byte_count <= beat.cnt;
				write_data <= beat.data;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_transfers.size() == 0) begin
					$display("%0t: unexpected result beat moved %h data %h", $time,
						moved_count, read_data);
					mismatches++;
				end else begin
					want = due_transfers.pop_front();
					check_field("moved_count", want.moved, moved_count);
					check_field("read_data", want.rdata, read_data);
					check_field("error_code", want.err, error_code);
					check_field("fill_level", want.fill, fill_level);
					check_field("free_space", want.room, free_space);
				end
			end
			if ($urandom_range(0, 299) == 0)
				rx_calm = !rx_calm;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(rx_calm) : 0;
				out_stall <= (stall_left != 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		int phase_len;
		int wr_share;
		int c;
		int cnt;
		logic [OPC_W-1:0] op;

		// empty store, zero counts, oversized counts
		add_request(OP_RD_PART, 8, '0, 1'b0);
		add_request(OP_RD_ALL, 1, '0, 1'b0);
		add_request(OP_WR_PART, 0, '1, 1'b0);
		add_request(OP_WR_ALL, 0, '1, 1'b0);
		add_request(OP_RD_PART, 0, '0, 1'b0);
		add_request(OP_RD_ALL, 0, '0, 1'b0);
		add_request(OP_WR_PART, 15, '1, 1'b0);
		add_request(OP_WR_ALL, 3, '0, 1'b0);
		add_request(OP_WR_PART, 9, 64'h0123_4567_89ab_cdef, 1'b0);
		add_request(OP_RD_ALL, 4, '0, 1'b0);
		add_request(OP_RD_PART, 15, '0, 1'b0);
		add_request(OP_RD_ALL, 8, '0, 1'b0);
		add_request(OP_RD_PART, 8, '0, 1'b0);
		add_request(OP_WR_ALL, 8, 64'hfedc_ba98_7654_3210, 1'b0);
		add_request(OP_WR_PART, 1, 64'h5a, 1'b0);
		add_request(OP_RD_ALL, 9, '0, 1'b0);
		add_request(OP_RD_PART, 1, '0, 1'b0);
		add_request(OP_WR_ALL, 12, {$urandom, $urandom}, 1'b0);
		add_request(OP_RD_PART, 8, '0, 1'b0);

		// random phases biased toward writes, reads or neither so the level sweeps
		// from empty to full and back, wrapping the pointers many times
		while (requests.size() < RANDOM_ITEMS) begin
			phase_len = $urandom_range(30, 120);
			c = $urandom_range(0, 2);
			wr_share = (c == 0) ? 80 : (c == 1) ? 20 : 50;
			for (int j = 0; j < phase_len && requests.size() < RANDOM_ITEMS; j++) begin
				if ($urandom_range(0, 99) < wr_share)
					op = $urandom_range(0, 1) ? OP_WR_ALL : OP_WR_PART;
				else
					op = $urandom_range(0, 1) ? OP_RD_ALL : OP_RD_PART;
				c = $urandom_range(0, 19);
				cnt = (c < 2) ? 0 : (c < 4) ? $urandom_range(9, 15) : $urandom_range(1, LANE);
				add_request(op, cnt, {$urandom, $urandom},
					requests.size() == 19 || requests.size() == 600);
			end
		end
		total_requests = requests.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_requests != total_requests)
			@(posedge clk);
		while (due_transfers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#8000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/brb_pkg.sv
hw/rtl/brb_ram.sv
hw/rtl/byte_ring_buffer_top.sv
test/tb.sv
